/* hw/rtl/rklsc_pkg.sv */
// Shared types, constants and weight helpers for the RKL stage coefficient block.
// No dependencies.
package rklsc_pkg;

    localparam int NLANE    = 4;
    localparam int LANE_MU  = 0;
    localparam int LANE_NU  = 1;
    localparam int LANE_TMU = 2;
    localparam int LANE_GAM = 3;

    // numerator / divisor / remainder / quotient widths of a lane
    localparam int RW = 60;
    localparam int DW = 57;
    localparam int QW = 33;

    localparam logic [31:0] MAG_MAX = 32'h7FFF_FFFF;

    localparam logic [7:0] CFG_ORDER = 8'd0;
    localparam logic [7:0] CFG_COUNT = 8'd1;

    typedef struct packed {
        logic             valid;
        logic             bad;
        logic             first;
        logic [NLANE-1:0] sat;
    } t_ctl;

    // numerator of b_k: (k-1)(k+2), and 1 for k below 2
    function automatic logic [15:0] b_num(input logic [7:0] k);
        logic [16:0] p;
        p = ({9'd0, k} - 17'd1) * ({9'd0, k} + 17'd2);
        if (k < 8'd2) begin
            return 16'd1;
        end
        return p[15:0];
    endfunction

    // denominator of b_k: 2k(k+1), and 3 for k below 2
    function automatic logic [16:0] b_den(input logic [7:0] k);
        logic [16:0] p;
        p = {9'd0, k} * ({9'd0, k} + 17'd1);
        if (k < 8'd2) begin
            return 17'd3;
        end
        return {p[15:0], 1'b0};
    endfunction

endpackage

/* hw/rtl/rkl_stage_coefficients.sv */
// Top level: config registers, front end, division cell chain, rounding and output.
// Depends on rklsc_pkg, rklsc_front, rklsc_cell.
//
//  channel   handshake                   payload
//  command   i_start / o_busy            i_stage_index
//  result    o_done (one cycle strobe)   o_coef_mu, o_coef_nu, o_coef_tmu,
//                                        o_coef_gamma, o_bad_request
//  config    i_cfg_valid / o_cfg_ready   i_cfg_addr, i_cfg_wdata
//
// One word is taken every cycle; o_busy stays low. Each result passes through
// four front-end register stages, then 33 division cells, one quotient bit per
// cell, then the rounding register. Synchronous reset clears the pipeline valid
// bits and sets order 0, count 2. Results cannot be stalled.
module rkl_stage_coefficients
    import rklsc_pkg::*;
#(
    parameter int STAGE_LIMIT = 255
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [7:0]  i_stage_index,
    output logic        o_done,
    output logic [31:0] o_coef_mu,
    output logic [31:0] o_coef_nu,
    output logic [31:0] o_coef_tmu,
    output logic [31:0] o_coef_gamma,
    output logic        o_bad_request,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_addr,
    input  logic [7:0]  i_cfg_wdata
);

    localparam int NCELL = QW;
    // front end, cells, output register
    localparam int LAT   = 5 + NCELL;

    logic       r_order;
    logic [7:0] r_count;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= 1'b0;
            r_count <= 8'd2;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_addr)
                CFG_ORDER: r_order <= i_cfg_wdata[0];
                CFG_COUNT: r_count <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    t_ctl          w_fctl;
    logic [RW-1:0] w_rem [NLANE][NCELL+1];
    logic [DW-1:0] w_den [NLANE][NCELL+1];
    logic [QW-1:0] w_quo [NLANE][NCELL+1];
    logic [RW-1:0] w_fnum [NLANE];
    logic [DW-1:0] w_fden [NLANE];

    rklsc_front #(
        .STAGE_LIMIT(STAGE_LIMIT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (i_start && !o_busy),
        .i_stage_index (i_stage_index),
        .i_order       (r_order),
        .i_count       (r_count),
        .o_ctl         (w_fctl),
        .o_num         (w_fnum),
        .o_den         (w_fden)
    );

    for (genvar l = 0; l < NLANE; l++) begin : g_lane
        assign w_rem[l][0] = w_fnum[l];
        assign w_den[l][0] = w_fden[l];
        assign w_quo[l][0] = '0;
        for (genvar c = 0; c < NCELL; c++) begin : g_cell
            rklsc_cell u_cell (
                .i_clk (i_clk),
                .i_rem (w_rem[l][c]),
                .i_den (w_den[l][c]),
                .i_quo (w_quo[l][c]),
                .o_rem (w_rem[l][c+1]),
                .o_den (w_den[l][c+1]),
                .o_quo (w_quo[l][c+1])
            );
        end
    end

    // control travels beside the cells
    t_ctl r_ctl [NCELL];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NCELL; c++) begin
                r_ctl[c] <= '0;
            end
        end else begin
            r_ctl[0] <= w_fctl;
            for (int c = 1; c < NCELL; c++) begin
                r_ctl[c] <= r_ctl[c-1];
            end
        end
    end

    t_ctl        w_lctl;
    logic [33:0] w_rq;
    logic [31:0] w_mag;
    logic [31:0] n_val [NLANE];

    // round half up on the extra quotient bit, clamp, apply sign; zero bad words and all but tmu on stage one
    always_comb begin
        w_lctl = r_ctl[NCELL-1];
        w_rq   = '0;
        w_mag  = '0;
        for (int l = 0; l < NLANE; l++) begin
            w_rq  = {1'b0, w_quo[l][NCELL]} + 34'd1;
            w_mag = (w_lctl.sat[l] || w_rq[33] || w_rq[32]) ? MAG_MAX : w_rq[32:1];
            if (l == LANE_NU || l == LANE_GAM) begin
                n_val[l] = 32'd0 - w_mag;
            end else begin
                n_val[l] = w_mag;
            end
            if (w_lctl.bad || (w_lctl.first && l != LANE_TMU)) begin
                n_val[l] = '0;
            end
        end
    end

    logic r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_lctl.valid;
        end
        o_coef_mu       <= n_val[LANE_MU];
        o_coef_nu       <= n_val[LANE_NU];
        o_coef_tmu      <= n_val[LANE_TMU];
        o_coef_gamma    <= n_val[LANE_GAM];
        o_bad_request   <= w_lctl.bad;
    end

    assign o_done = r_done;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##LAT o_done)
        else $error("result strobe missing at fixed latency");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_bad_request) |-> (o_coef_mu == 32'd0 && o_coef_nu == 32'd0
            && o_coef_tmu == 32'd0 && o_coef_gamma == 32'd0))
        else $error("rejected request carries nonzero coefficients");

    a_tmu_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_bad_request) |-> (o_coef_tmu != 32'd0 && !o_coef_tmu[31]))
        else $error("scaled mu not positive on a valid request");

    a_mu_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_bad_request) |-> (!o_coef_mu[31] && (o_coef_nu == 32'd0 || o_coef_nu[31])))
        else $error("mu or nu has the wrong sign");

endmodule

/* hw/rtl/rklsc_front.sv */
// Front end: forms numerator and divisor of each coefficient as exact integers.
// Depends on rklsc_pkg.
module rklsc_front
    import rklsc_pkg::*;
#(
    parameter int STAGE_LIMIT = 255
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_take,
    input  logic [7:0]    i_stage_index,
    input  logic          i_order,
    input  logic [7:0]    i_count,
    output t_ctl          o_ctl,
    output logic [RW-1:0] o_num [NLANE],
    output logic [DW-1:0] o_den [NLANE]
);

    // stage 1: small terms
    t_ctl        r1_ctl, n1_ctl;
    logic [8:0]  r1_a, n1_a;
    logic [7:0]  r1_j, r1_jm1;
    logic [15:0] r1_bnj, r1_bnp, r1_bnq, r1_sp, n1_bnj, n1_bnp, n1_bnq, n1_sp;
    logic [16:0] r1_bdj, r1_bdp, r1_bdq, n1_bdj, n1_bdp, n1_bdq;
    logic        r1_cw4;

    always_comb begin
        n1_ctl.valid = i_take;
        n1_ctl.bad   = (i_stage_index == 8'd0) || (i_stage_index > i_count)
                       || (int'(i_count) > STAGE_LIMIT) || (i_order && i_count < 8'd2);
        n1_ctl.first = (i_stage_index == 8'd1);
        n1_ctl.sat   = '0;
        n1_a = {i_stage_index, 1'b0} - 9'd1;
        if (i_order) begin
            n1_bnj = b_num(i_stage_index);
            n1_bdj = b_den(i_stage_index);
            n1_bnp = b_num(i_stage_index - 8'd1);
            n1_bdp = b_den(i_stage_index - 8'd1);
            n1_bnq = b_num(i_stage_index - 8'd2);
            n1_bdq = b_den(i_stage_index - 8'd2);
            n1_sp  = 16'(({8'd0, i_count} - 16'd1) * ({8'd0, i_count} + 16'd2));
            // stage one takes w1 times b_1 alone
            if (n1_ctl.first) begin
                n1_bnp = 16'd1;
                n1_bdp = 17'd1;
            end
        end else begin
            n1_bnj = 16'd1;
            n1_bdj = 17'd1;
            n1_bnp = 16'd1;
            n1_bdp = 17'd1;
            n1_bnq = 16'd1;
            n1_bdq = 17'd1;
            n1_sp  = 16'({8'd0, i_count} * ({8'd0, i_count} + 16'd1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
        end else begin
            r1_ctl <= n1_ctl;
        end
        r1_a   <= n1_a;
        r1_j   <= i_stage_index;
        r1_jm1 <= i_stage_index - 8'd1;
        r1_bnj <= n1_bnj;
        r1_bdj <= n1_bdj;
        r1_bnp <= n1_bnp;
        r1_bdp <= n1_bdp;
        r1_bnq <= n1_bnq;
        r1_bdq <= n1_bdq;
        r1_sp  <= n1_sp;
        r1_cw4 <= i_order;
    end

    // stage 2: first products
    t_ctl        r2_ctl;
    logic [24:0] r2_m1, r2_m2;
    logic [23:0] r2_n1;
    logic [31:0] r2_q;
    logic [16:0] r2_gd, r2_bdp, r2_bdq;
    logic [15:0] r2_bnp, r2_bnq;
    logic        r2_cw4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_ctl <= '0;
        end else begin
            r2_ctl <= r1_ctl;
        end
        r2_m1  <= 25'(r1_a) * 25'(r1_bnj);
        r2_m2  <= 25'(r1_j) * 25'(r1_bdj);
        r2_n1  <= 24'(r1_jm1) * 24'(r1_bnj);
        r2_q   <= 32'(r1_bnp) * 32'(r1_sp);
        r2_gd  <= r1_bdp - 17'(r1_bnp);
        r2_bdp <= r1_bdp;
        r2_bdq <= r1_bdq;
        r2_bnp <= r1_bnp;
        r2_bnq <= r1_bnq;
        r2_cw4 <= r1_cw4;
    end

    // stage 3: lane numerators and divisors
    t_ctl          r3_ctl;
    logic [RW-1:0] r3_num [NLANE];
    logic [DW-1:0] r3_den [NLANE];
    logic [41:0]   w_mun, w_gp;
    logic [43:0]   w_tn, w_gn;
    logic [56:0]   w_td;

    always_comb begin
        w_mun = 42'(r2_m1) * 42'(r2_bdp);
        w_gp  = 42'(r2_m1) * 42'(r2_gd);
        w_td  = 57'(r2_m2) * 57'(r2_q);
        w_tn  = r2_cw4 ? {w_mun, 2'b00} : {1'b0, w_mun, 1'b0};
        w_gn  = r2_cw4 ? {w_gp, 2'b00} : {1'b0, w_gp, 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_ctl <= '0;
        end else begin
            r3_ctl <= r2_ctl;
        end
        r3_num[LANE_MU]  <= RW'(w_mun);
        r3_den[LANE_MU]  <= DW'(41'(r2_m2) * 41'(r2_bnp));
        r3_num[LANE_NU]  <= RW'(41'(r2_n1) * 41'(r2_bdq));
        r3_den[LANE_NU]  <= DW'(41'(r2_m2) * 41'(r2_bnq));
        r3_num[LANE_TMU] <= RW'(w_tn);
        r3_den[LANE_TMU] <= w_td;
        r3_num[LANE_GAM] <= RW'(w_gn);
        r3_den[LANE_GAM] <= w_td;
    end

    // stage 4: flag quotients of eight or more
    t_ctl n4_ctl;

    always_comb begin
        n4_ctl = r3_ctl;
        for (int l = 0; l < NLANE; l++) begin
            n4_ctl.sat[l] = (r3_num[l] >= {r3_den[l], 3'b000});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl <= '0;
        end else begin
            o_ctl <= n4_ctl;
        end
        o_num <= r3_num;
        o_den <= r3_den;
    end

endmodule

/* hw/rtl/rklsc_cell.sv */
// One restoring division step: one quotient bit per cell, handed on each cycle.
// Depends on rklsc_pkg.
module rklsc_cell
    import rklsc_pkg::*;
(
    input  logic          i_clk,
    input  logic [RW-1:0] i_rem,
    input  logic [DW-1:0] i_den,
    input  logic [QW-1:0] i_quo,
    output logic [RW-1:0] o_rem,
    output logic [DW-1:0] o_den,
    output logic [QW-1:0] o_quo
);

    logic [RW-1:0] w_d4, w_diff;
    logic          w_ge;

    always_comb begin
        w_d4   = RW'({i_den, 2'b00});
        w_ge   = (i_rem >= w_d4);
        w_diff = w_ge ? (i_rem - w_d4) : i_rem;
    end

    // remainder stays below four divisors, so the shift drops nothing
    always_ff @(posedge i_clk) begin
        o_rem <= {w_diff[RW-2:0], 1'b0};
        o_den <= i_den;
        o_quo <= {i_quo[QW-2:0], w_ge};
    end

endmodule

/* test/tb_rkl_stage_coefficients.sv */
// Testbench for rkl_stage_coefficients: directed table, then random stage words,
// with both config registers swept. Depends on rklsc_pkg and the RTL top level.
module tb_rkl_stage_coefficients;
    import rklsc_pkg::*;

    localparam int STAGE_LIMIT = 255;
    localparam int DRAIN_CYC   = 45;   // pipeline is 38 deep

    typedef struct {
        longint unsigned n;
        longint unsigned d;
    } t_ratio;

    typedef struct {
        logic [31:0] mu;
        logic [31:0] nu;
        logic [31:0] tmu;
        logic [31:0] gam;
        logic        bad;
    } t_coef;

    typedef struct {
        logic        order;
        logic [7:0]  count;
        logic [7:0]  stage;
        bit          typed;
        t_coef       want;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic [7:0]  i_stage_index;
    logic        o_done;
    logic [31:0] o_coef_mu;
    logic [31:0] o_coef_nu;
    logic [31:0] o_coef_tmu;
    logic [31:0] o_coef_gamma;
    logic        o_bad_request;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_addr;
    logic [7:0]  i_cfg_wdata;

    t_coef pending_coefs[$];
    int    mismatch_cnt;
    logic  cur_order;
    logic [7:0] cur_count;

    rkl_stage_coefficients #(.STAGE_LIMIT(STAGE_LIMIT)) dut (.*);

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // ---------------- exact rational predictor ----------------
    function automatic longint unsigned gcd64(longint unsigned a, longint unsigned b);
        longint unsigned t;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    function automatic t_ratio rat(longint unsigned n, longint unsigned d);
        t_ratio r;
        longint unsigned g;
        g = gcd64(n, d);
        if (g == 0) g = 1;
        r.n = n / g;
        r.d = d / g;
        return r;
    endfunction

    function automatic t_ratio rat_mul(t_ratio a, t_ratio b);
        longint unsigned g1, g2;
        g1 = gcd64(a.n, b.d);
        g2 = gcd64(b.n, a.d);
        if (g1 == 0) g1 = 1;
        if (g2 == 0) g2 = 1;
        return rat((a.n / g1) * (b.n / g2), (a.d / g2) * (b.d / g1));
    endfunction

    function automatic t_ratio rat_div(t_ratio a, t_ratio b);
        t_ratio inv;
        inv.n = b.d;
        inv.d = b.n;
        return rat_mul(a, inv);
    endfunction

    function automatic t_ratio legendre_weight(longint unsigned k);
        if (k < 2) return rat(1, 3);
        return rat((k - 1) * (k + 2), 2 * k * (k + 1));
    endfunction

    // round magnitude to nearest 2^-29, ties away from zero, clamp
    function automatic logic [31:0] q29_mag(t_ratio f);
        longint unsigned q, r;
        if (f.d == 0) return MAG_MAX;
        q = f.n / f.d;
        r = f.n % f.d;
        if (q > 7) return MAG_MAX;
        for (int i = 0; i < 29; i++) begin
            q = q << 1;
            r = r << 1;
            if (r >= f.d) begin
                r = r - f.d;
                q = q | 1;
            end
        end
        if ((r << 1) >= f.d) q++;
        if (q > MAG_MAX) q = MAG_MAX;
        return q[31:0];
    endfunction

    function automatic t_coef predict_coefs(logic order, logic [7:0] count, logic [7:0] stage);
        t_coef c;
        longint unsigned j, s;
        t_ratio w1, mu, nu, tmu, gam, bp;
        j = stage;
        s = count;
        c = '{32'd0, 32'd0, 32'd0, 32'd0, 1'b0};
        if (j == 0 || j > s || s > STAGE_LIMIT || (order && s < 2)) begin
            c.bad = 1'b1;
            return c;
        end
        if (!order) begin
            w1 = rat(2, s * (s + 1));
            if (j == 1) begin
                c.tmu = q29_mag(w1);
                return c;
            end
            mu  = rat(2 * j - 1, j);
            nu  = rat(j - 1, j);
            tmu = rat_mul(mu, w1);
            c.mu  = q29_mag(mu);
            c.nu  = -q29_mag(nu);
            c.tmu = q29_mag(tmu);
            return c;
        end
        w1 = rat(4, (s - 1) * (s + 2));
        if (j == 1) begin
            c.tmu = q29_mag(rat_mul(legendre_weight(1), w1));
            return c;
        end
        mu  = rat_mul(rat(2 * j - 1, j),
                      rat_div(legendre_weight(j), legendre_weight(j - 1)));
        nu  = rat_mul(rat(j - 1, j),
                      rat_div(legendre_weight(j), legendre_weight(j - 2)));
        tmu = rat_mul(mu, w1);
        bp  = legendre_weight(j - 1);
        gam = rat_mul(rat(bp.d - bp.n, bp.d), tmu);
        c.mu  = q29_mag(mu);
        c.nu  = -q29_mag(nu);
        c.tmu = q29_mag(tmu);
        c.gam = -q29_mag(gam);
        return c;
    endfunction

    // ---------------- result check ----------------
    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH @%0t %s: got %h want %h", $realtime, what, got, want);
        mismatch_cnt++;
    endtask

    always @(posedge i_clk) begin
        t_coef w;
        if (i_rst_n && o_done) begin
            if (pending_coefs.size() == 0) begin
                report_mismatch("unexpected word", 32'd0, 32'd0);
            end else begin
                w = pending_coefs.pop_front();
                if (o_coef_mu !== w.mu) report_mismatch("mu", o_coef_mu, w.mu);
                if (o_coef_nu !== w.nu) report_mismatch("nu", o_coef_nu, w.nu);
                if (o_coef_tmu !== w.tmu)
                    report_mismatch("tmu", o_coef_tmu, w.tmu);
                if (o_coef_gamma !== w.gam) report_mismatch("gamma", o_coef_gamma, w.gam);
                if (o_bad_request !== w.bad)
                    report_mismatch("bad_request", {31'd0, o_bad_request}, {31'd0, w.bad});
            end
        end
    end

    // ---------------- drivers ----------------
    // drop start first so no stray word slips in while draining
    task automatic wait_drained();
        i_start <= 1'b0;
        while (pending_coefs.size() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [7:0] addr, logic [7:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        if (addr == CFG_ORDER) cur_order = data[0];
        else if (addr == CFG_COUNT) cur_count = data;
    endtask

    // drain, then set both registers; upper order bits are don't-care
    task automatic set_mode(logic order, logic [7:0] count);
        wait_drained();
        repeat (DRAIN_CYC) @(posedge i_clk);
        cfg_write(CFG_ORDER, {7'($urandom), order});
        cfg_write(CFG_COUNT, count);
    endtask

    // hold start across back-to-back words, drop it only for a gap
    task automatic send_word(logic [7:0] stage, t_coef want, int gap);
        i_start       <= 1'b1;
        i_stage_index <= stage;
        do @(posedge i_clk); while (o_busy);
        pending_coefs.push_back(want);
        if (gap > 0) begin
            i_start       <= 1'b0;
            i_stage_index <= 8'($urandom);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    t_row plan[$];
    t_coef zeros_bad = '{32'd0, 32'd0, 32'd0, 32'd0, 1'b1};

    task automatic add_row(logic order, logic [7:0] count, logic [7:0] stage,
                           bit typed, t_coef want);
        plan.push_back('{order, count, stage, typed, want});
    endtask

    initial begin
        t_coef  none;
        t_coef  third;
        t_coef  unity;
        int     gap_max;
        logic [7:0] cnt;
        logic [7:0] stage;

        none  = '{32'd0, 32'd0, 32'd0, 32'd0, 1'b0};
        third = '{32'd0, 32'd0, 32'h0AAA_AAAB, 32'd0, 1'b0};
        unity = '{32'd0, 32'd0, 32'h2000_0000, 32'd0, 1'b0};
        mismatch_cnt  = 0;
        i_rst_n       = 1'b0;
        i_start       = 1'b0;
        i_stage_index = 8'd0;
        i_cfg_valid   = 1'b0;
        i_cfg_addr    = 8'd0;
        i_cfg_wdata   = 8'd0;
        cur_order     = 1'b0;
        cur_count     = 8'd2;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values: order 0, count 2
        add_row(1'b0, 8'd2,   8'd1,   1, third);
        add_row(1'b0, 8'd2,   8'd0,   1, zeros_bad);
        add_row(1'b0, 8'd2,   8'd3,   1, zeros_bad);
        add_row(1'b0, 8'd2,   8'd2,   0, none);
        add_row(1'b0, 8'd2,   8'd255, 1, zeros_bad);
        add_row(1'b0, 8'd1,   8'd1,   1, unity);
        add_row(1'b0, 8'd0,   8'd1,   1, zeros_bad);
        add_row(1'b0, 8'd255, 8'd1,   0, none);
        add_row(1'b0, 8'd255, 8'd128, 0, none);
        add_row(1'b0, 8'd255, 8'd255, 0, none);
        add_row(1'b1, 8'd1,   8'd1,   1, zeros_bad);
        add_row(1'b1, 8'd0,   8'd0,   1, zeros_bad);
        add_row(1'b1, 8'd2,   8'd1,   1, third);
        add_row(1'b1, 8'd2,   8'd2,   0, none);
        add_row(1'b1, 8'd3,   8'd3,   0, none);
        add_row(1'b1, 8'd3,   8'd4,   1, zeros_bad);
        add_row(1'b1, 8'd255, 8'd1,   0, none);
        add_row(1'b1, 8'd255, 8'd2,   0, none);
        add_row(1'b1, 8'd255, 8'd127, 0, none);
        add_row(1'b1, 8'd255, 8'd255, 0, none);
        add_row(1'b1, 8'd255, 8'd0,   1, zeros_bad);

        foreach (plan[k]) begin
            if (k != 0 && (plan[k].order != cur_order || plan[k].count != cur_count)) begin
                set_mode(plan[k].order, plan[k].count);
                // out-of-range register index must be ignored
                if (k == 5) cfg_write(8'd2, 8'($urandom));
            end
            send_word(plan[k].stage,
                      plan[k].typed ? plan[k].want
                                    : predict_coefs(cur_order, cur_count, plan[k].stage),
                      $urandom_range(0, 3));
        end

        // random phases; mostly valid stages, some zero or out-of-range noise
        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: cnt = 8'd255;
                1: cnt = 8'd1;
                2: cnt = 8'd2;
                3: cnt = 8'd3;
                4: cnt = 8'd255;
                default: cnt = 8'($urandom_range(0, 255));
            endcase
            set_mode(ph[0], cnt);
            gap_max = (ph % 3 == 0) ? 0 : 19;
            for (int n = 0; n < 200; n++) begin
                if (ph == 3 && n == 100) wait_drained();
                if ($urandom_range(0, 9) < 8 && cur_count != 0)
                    stage = 8'($urandom_range(1, cur_count));
                else
                    stage = 8'($urandom);
                send_word(stage, predict_coefs(cur_order, cur_count, stage),
                          ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, gap_max));
            end
        end

        wait_drained();
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (mismatch_cnt == 0 && pending_coefs.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
